>>> rtl/core/gsa_pkg.sv
// Shared types and codes for the global sequence alignment unit.
package gsa_pkg;

    localparam logic [1:0] ACT_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] ACT_LOAD_SECOND = 2'd1;
    localparam logic [1:0] ACT_RUN         = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_GAP  = 2'd1;
    localparam logic [1:0] ERR_LONG = 2'd2;

    localparam logic [7:0] GAP_SYMBOL_RESET = 8'd45;

    typedef enum logic [1:0] {
        DIR_DIAG,
        DIR_UP,
        DIR_LEFT
    } t_dir;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INIT,
        S_ROW,
        S_FILL,
        S_TRACE,
        S_EMIT,
        S_SINGLE
    } t_state;

    typedef struct packed {
        logic signed [6:0] score;
        logic              has_column;
        logic [7:0]        first_column;
        logic [7:0]        second_column;
        logic [1:0]        error;
        logic              last;
    } t_result;

endpackage

>>> rtl/core/gsa_if.sv
// Valid/ready channel interfaces for the alignment unit's input and result items.
interface gsa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] symbol;

    modport source(output valid, output action, output symbol, input ready);
    modport sink(input valid, input action, input symbol, output ready);
endinterface

interface gsa_out_if;
    logic              valid;
    logic              ready;
    logic signed [6:0] score;
    logic              has_column;
    logic [7:0]        first_column;
    logic [7:0]        second_column;
    logic [1:0]        error;
    logic              last;

    modport source(output valid, output score, output has_column, output first_column,
                   output second_column, output error, output last, input ready);
    modport sink(input valid, input score, input has_column, input first_column,
                 input second_column, input error, input last, output ready);
endinterface

>>> rtl/core/gsa_out_stage.sv
// Output register that holds one result item until the receiver takes it.
module gsa_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  gsa_pkg::t_result i_res,
    output logic             o_free,
    gsa_out_if.source        o_res
);
    import gsa_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.score         = r_res.score;
    assign o_res.has_column    = r_res.has_column;
    assign o_res.first_column  = r_res.first_column;
    assign o_res.second_column = r_res.second_column;
    assign o_res.error         = r_res.error;
    assign o_res.last          = r_res.last;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free) else $error("result loaded over an untaken item");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> o_res.valid) else $error("loaded item not presented");
    a_rise_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(i_load)) else $error("valid rose without a load");
`endif

endmodule

>>> rtl/core/global_sequence_alignment_unit.sv
// Global sequence alignment unit: loads two byte sequences, aligns them on a run item.
//
// Input channel i_in: action 0 appends symbol to the first sequence, 1 to the second,
// 2 starts a run; action 3 is ignored. Load items are taken one per cycle while idle.
// Loads past MAX_LEN are dropped and flag the run with error 2.
// Result channel o_res: a run gives one item per aligned column, in forward order, each
// carrying the final score, the last one marked. An error or two empty sequences give a
// single item with has_column low. A run clears both sequences.
// A run scans both sequences for the gap symbol; unless it gives a single item, it then
// writes the border row, fills the table row by row with one shared add/compare unit,
// traces back and emits the columns. i_in.ready is low for the whole run. The result
// sits in an output register, so a stalled receiver only holds the emit loop or the
// single item; nothing is lost. Reset (synchronous, active low) empties both sequences,
// clears the error flags and the output register and sets gap_symbol to 45. No clearing
// pass is needed: every table entry read in a run is written earlier in that run. The
// user writes gap_symbol through i_cfg_we/i_cfg_data only while the block is idle, which
// the block itself does not enforce.
module global_sequence_alignment_unit #(
    parameter int MAX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    gsa_in_if.sink     i_in,
    gsa_out_if.source  o_res
);
    import gsa_pkg::*;

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int SW  = LW + 2;
    localparam int TD  = MAX_LEN + 1;
    localparam int DA  = $clog2(TD * TD);
    localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW  = $clog2(2 * MAX_LEN);
    localparam int NW  = $clog2(2 * MAX_LEN + 1);
    localparam logic signed [SW-1:0] ONE = SW'(1);

    t_state r_state, n_state;
    logic   r_ph, n_ph;
    logic [7:0] r_gap_sym;
    logic [LW-1:0] r_len1, n_len1, r_len2, n_len2;
    logic r_ovf, n_ovf, r_gap_seen, n_gap_seen;
    logic [LW-1:0] r_i, n_i, r_j, n_j;
    logic [NW-1:0] r_k, n_k, r_n, n_n;
    logic signed [SW-1:0] r_left, n_left, r_diag, n_diag, r_score, n_score;

    logic [7:0]          m_first [MAX_LEN];
    logic [7:0]          m_second[MAX_LEN];
    logic signed [SW-1:0] m_row  [TD];
    t_dir                m_dir   [TD*TD];
    logic [15:0]         m_col   [2*MAX_LEN];

    logic [7:0]           r_fa_rd, r_sb_rd;
    logic signed [SW-1:0] r_row_rd;
    t_dir                 r_dir_rd;
    logic [15:0]          r_col_rd;

    logic accept, ld_first, ld_second, out_free, out_load;
    t_result out_res;

    logic [SAW-1:0] fa_addr, sb_addr;
    logic           row_we, dir_we, col_we;
    logic [LW-1:0]  row_waddr;
    logic signed [SW-1:0] row_wdata;
    logic [DA-1:0]  cell_addr, dir_waddr;
    t_dir           dir_wdata;
    logic [CW-1:0]  col_raddr;

    logic [LW-1:0] i_m1, j_m1, maxlen;
    logic signed [SW-1:0] neg_i, neg_j, neg_im1;
    logic signed [SW-1:0] up_val, left_val, diag_val, umax, best;
    logic up_ge, diag_take, scan_done, row_end, last_row, emit_last, tr_end;
    logic [LW-1:0] tr_i, tr_j;
    logic [7:0] tr_a, tr_b;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign ld_first  = accept && (i_in.action == ACT_LOAD_FIRST);
    assign ld_second = accept && (i_in.action == ACT_LOAD_SECOND);

    assign i_m1    = r_i - LW'(1);
    assign j_m1    = r_j - LW'(1);
    assign neg_i   = -$signed(SW'(r_i));
    assign neg_j   = -$signed(SW'(r_j));
    assign neg_im1 = -$signed(SW'(i_m1));
    assign maxlen  = (r_len1 > r_len2) ? r_len1 : r_len2;
    assign cell_addr = DA'(DA'(r_i) * DA'(TD) + DA'(r_j));

    // Shared add/compare unit for one table cell.
    assign up_val    = r_row_rd - ONE;
    assign left_val  = r_left - ONE;
    assign diag_val  = (r_fa_rd == r_sb_rd) ? r_diag + ONE : r_diag - ONE;
    assign up_ge     = (up_val >= left_val);
    assign umax      = up_ge ? up_val : left_val;
    assign diag_take = (diag_val >= umax);
    assign best      = diag_take ? diag_val : umax;

    assign scan_done = (r_k >= NW'(maxlen));
    assign row_end   = (r_j == r_len2);
    assign last_row  = (r_i == r_len1);
    assign emit_last = (r_k == r_n - NW'(1));
    assign col_raddr = CW'(r_n - r_k - NW'(1));

    always_comb begin
        tr_i = r_i;
        tr_j = r_j;
        tr_a = r_fa_rd;
        tr_b = r_sb_rd;
        case (r_dir_rd)
            DIR_DIAG: begin
                tr_i = i_m1;
                tr_j = j_m1;
            end
            DIR_UP: begin
                tr_i = i_m1;
                tr_b = r_gap_sym;
            end
            default: begin
                tr_j = j_m1;
                tr_a = r_gap_sym;
            end
        endcase
    end
    assign tr_end = (tr_i == '0) && (tr_j == '0);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in.action == ACT_RUN) begin
                    n_state = S_SCAN;
                    n_ph    = 1'b0;
                end
            end
            S_SCAN: begin
                if (r_ph) begin
                    n_ph = 1'b0;
                end else if (scan_done) begin
                    if (r_ovf || r_gap_seen || (r_len1 == '0 && r_len2 == '0)) begin
                        n_state = S_SINGLE;
                    end else begin
                        n_state = S_INIT;
                    end
                end else begin
                    n_ph = 1'b1;
                end
            end
            S_INIT: begin
                if (row_end) begin
                    n_state = (r_len1 == '0) ? S_TRACE : S_ROW;
                    n_ph    = 1'b0;
                end
            end
            S_ROW: begin
                if (r_len2 != '0) begin
                    n_state = S_FILL;
                    n_ph    = 1'b0;
                end else if (last_row) begin
                    n_state = S_TRACE;
                    n_ph    = 1'b0;
                end
            end
            S_FILL: begin
                n_ph = !r_ph;
                if (r_ph && row_end) begin
                    n_state = last_row ? S_TRACE : S_ROW;
                end
            end
            S_TRACE: begin
                n_ph = !r_ph;
                if (r_ph && tr_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (out_free) begin
                    n_ph = 1'b0;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ph    = 1'b0;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_len1     = r_len1;
        n_len2     = r_len2;
        n_ovf      = r_ovf;
        n_gap_seen = r_gap_seen;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_n        = r_n;
        n_left     = r_left;
        n_diag     = r_diag;
        n_score    = r_score;
        fa_addr    = SAW'(i_m1);
        sb_addr    = SAW'(j_m1);
        row_we     = 1'b0;
        row_waddr  = r_j;
        row_wdata  = best;
        dir_we     = 1'b0;
        dir_waddr  = cell_addr;
        dir_wdata  = DIR_LEFT;
        col_we     = 1'b0;
        out_load   = 1'b0;
        out_res    = '0;
        case (r_state)
            S_IDLE: begin
                if (ld_first) begin
                    if (r_len1 < LW'(MAX_LEN)) n_len1 = r_len1 + LW'(1);
                    else                       n_ovf  = 1'b1;
                end
                if (ld_second) begin
                    if (r_len2 < LW'(MAX_LEN)) n_len2 = r_len2 + LW'(1);
                    else                       n_ovf  = 1'b1;
                end
                n_k        = '0;
                n_gap_seen = 1'b0;
            end
            S_SCAN: begin
                fa_addr = SAW'(r_k);
                sb_addr = SAW'(r_k);
                if (r_ph) begin
                    if (r_k < NW'(r_len1) && r_fa_rd == r_gap_sym) n_gap_seen = 1'b1;
                    if (r_k < NW'(r_len2) && r_sb_rd == r_gap_sym) n_gap_seen = 1'b1;
                    n_k = r_k + NW'(1);
                end else if (scan_done) begin
                    // The border row is written at row zero.
                    n_i = '0;
                    n_j = '0;
                end
            end
            S_INIT: begin
                row_we    = 1'b1;
                row_wdata = neg_j;
                dir_we    = 1'b1;
                dir_wdata = DIR_LEFT;
                n_score   = neg_j;
                if (row_end) begin
                    n_i = (r_len1 == '0) ? '0 : LW'(1);
                    n_n = '0;
                end else begin
                    n_j = r_j + LW'(1);
                end
            end
            S_ROW: begin
                // Column zero of a row; the old row entry zero is the diagonal input.
                row_we    = 1'b1;
                row_waddr = '0;
                row_wdata = neg_i;
                dir_we    = 1'b1;
                dir_waddr = DA'(DA'(r_i) * DA'(TD));
                dir_wdata = DIR_UP;
                n_score   = neg_i;
                n_left    = neg_i;
                n_diag    = neg_im1;
                n_j       = (r_len2 == '0) ? '0 : LW'(1);
                if (r_len2 == '0 && !last_row) n_i = r_i + LW'(1);
            end
            S_FILL: begin
                if (r_ph) begin
                    row_we    = 1'b1;
                    dir_we    = 1'b1;
                    dir_wdata = diag_take ? DIR_DIAG : (up_ge ? DIR_UP : DIR_LEFT);
                    n_score   = best;
                    n_left    = best;
                    n_diag    = r_row_rd;
                    if (row_end) begin
                        if (!last_row) n_i = r_i + LW'(1);
                    end else begin
                        n_j = r_j + LW'(1);
                    end
                end
            end
            S_TRACE: begin
                if (r_ph) begin
                    col_we = 1'b1;
                    n_n    = r_n + NW'(1);
                    n_i    = tr_i;
                    n_j    = tr_j;
                    n_k    = '0;
                end
            end
            S_EMIT: begin
                out_res.score         = 7'(r_score);
                out_res.has_column    = 1'b1;
                out_res.first_column  = r_col_rd[15:8];
                out_res.second_column = r_col_rd[7:0];
                out_res.error         = ERR_NONE;
                out_res.last          = emit_last;
                if (r_ph && out_free) begin
                    out_load = 1'b1;
                    n_k      = r_k + NW'(1);
                    if (emit_last) begin
                        n_len1 = '0;
                        n_len2 = '0;
                        n_ovf  = 1'b0;
                    end
                end
            end
            S_SINGLE: begin
                out_res.last  = 1'b1;
                out_res.error = r_ovf ? ERR_LONG : (r_gap_seen ? ERR_GAP : ERR_NONE);
                if (out_free) begin
                    out_load   = 1'b1;
                    n_len1     = '0;
                    n_len2     = '0;
                    n_ovf      = 1'b0;
                    n_gap_seen = 1'b0;
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ph       <= 1'b0;
            r_gap_sym  <= GAP_SYMBOL_RESET;
            r_len1     <= '0;
            r_len2     <= '0;
            r_ovf      <= 1'b0;
            r_gap_seen <= 1'b0;
            r_n        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_ph       <= n_ph;
            r_len1     <= n_len1;
            r_len2     <= n_len2;
            r_ovf      <= n_ovf;
            r_gap_seen <= n_gap_seen;
            r_n        <= n_n;
            r_k        <= n_k;
            if (i_cfg_we) r_gap_sym <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_left  <= n_left;
        r_diag  <= n_diag;
        r_score <= n_score;
    end

    always_ff @(posedge i_clk) begin
        if (ld_first && r_len1 < LW'(MAX_LEN)) m_first[SAW'(r_len1)] <= i_in.symbol;
        r_fa_rd <= m_first[fa_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ld_second && r_len2 < LW'(MAX_LEN)) m_second[SAW'(r_len2)] <= i_in.symbol;
        r_sb_rd <= m_second[sb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (row_we) m_row[row_waddr] <= row_wdata;
        r_row_rd <= m_row[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) m_dir[dir_waddr] <= dir_wdata;
        r_dir_rd <= m_dir[cell_addr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) m_col[CW'(r_n)] <= {tr_a, tr_b};
        r_col_rd <= m_col[col_raddr];
    end

    gsa_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_res   (out_res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_i != '0 && r_j != '0 && r_i <= r_len1 && r_j <= r_len2))
        else $error("fill cell outside the table");
    a_column_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= NW'(2 * MAX_LEN)) else $error("column buffer overrun");
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < r_n)) else $error("emit index past column count");
    a_single_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SINGLE && out_free) |=> (r_state == S_IDLE && r_len1 == '0))
        else $error("run did not finish after its single item");
`endif

endmodule

>>> tb/gsa_tb_pkg.sv
`timescale 1ns / 100ps
// Column record type shared by the alignment testbench modules.
package gsa_tb_pkg;

    typedef struct packed {
        logic signed [6:0] score;
        logic              has_column;
        logic [7:0]        first_column;
        logic [7:0]        second_column;
        logic [1:0]        error;
        logic              last;
    } t_column_rec;

endpackage

>>> tb/gsa_alignment_checker.sv
`timescale 1ns / 100ps
// Checker that predicts the alignment columns of each run and compares the result items.
module gsa_alignment_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [7:0]              i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_in_action,
    input  logic [7:0]              i_in_symbol,
    input  logic                    i_res_valid,
    input  logic                    i_res_ready,
    input  gsa_tb_pkg::t_column_rec i_res,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_result_count
);
    import gsa_pkg::*;
    import gsa_tb_pkg::*;

    localparam int SEQ_MAX = 32;

    logic [7:0]  model_gap;
    logic [7:0]  model_first [SEQ_MAX];
    logic [7:0]  model_second [SEQ_MAX];
    int          model_first_len;
    int          model_second_len;
    logic        model_overflow;
    t_column_rec expected_columns[$];

    assign o_pending = expected_columns.size();

    task automatic report_mismatch(input string what, input t_column_rec got,
                                   input t_column_rec want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    task automatic queue_expected(input t_column_rec rec);
        expected_columns = {expected_columns, rec};
    endtask

    function automatic t_column_rec make_rec(input int sc, input logic has,
                                             input logic [7:0] a, input logic [7:0] b,
                                             input logic [1:0] err, input logic lst);
        t_column_rec r;
        r.score = sc[6:0];
        r.has_column = has;
        r.first_column = a;
        r.second_column = b;
        r.error = err;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_alignment();
        int          tbl [SEQ_MAX+1][SEQ_MAX+1];
        int          i, j, up, lft, dg, best, sc;
        logic        gap_hit;
        logic [15:0] path[$];
        logic [7:0]  a, b;
        gap_hit = 1'b0;
        for (i = 0; i < model_first_len; i++)
            if (model_first[i] == model_gap) gap_hit = 1'b1;
        for (i = 0; i < model_second_len; i++)
            if (model_second[i] == model_gap) gap_hit = 1'b1;
        if (model_overflow || gap_hit) begin
            queue_expected(make_rec(0, 1'b0, 8'd0, 8'd0,
                                    model_overflow ? ERR_LONG : ERR_GAP, 1'b1));
        end else if (model_first_len == 0 && model_second_len == 0) begin
            queue_expected(make_rec(0, 1'b0, 8'd0, 8'd0, ERR_NONE, 1'b1));
        end else begin
            for (j = 0; j <= model_second_len; j++) tbl[0][j] = -j;
            for (i = 0; i <= model_first_len; i++) tbl[i][0] = -i;
            for (i = 1; i <= model_first_len; i++) begin
                for (j = 1; j <= model_second_len; j++) begin
                    up = tbl[i-1][j] - 1;
                    lft = tbl[i][j-1] - 1;
                    dg = tbl[i-1][j-1] + (model_first[i-1] == model_second[j-1] ? 1 : -1);
                    best = up > lft ? up : lft;
                    if (dg > best) best = dg;
                    tbl[i][j] = best;
                end
            end
            sc = tbl[model_first_len][model_second_len];
            i = model_first_len;
            j = model_second_len;
            // Walk back preferring diagonal, then a first-only step, then second-only.
            while (i > 0 || j > 0) begin
                if (i > 0 && j > 0 && tbl[i][j] == tbl[i-1][j-1] +
                        (model_first[i-1] == model_second[j-1] ? 1 : -1)) begin
                    a = model_first[i-1]; b = model_second[j-1]; i--; j--;
                end else if (i > 0 && (j == 0 || tbl[i][j] == tbl[i-1][j] - 1)) begin
                    a = model_first[i-1]; b = model_gap; i--;
                end else begin
                    a = model_gap; b = model_second[j-1]; j--;
                end
                path.push_front({a, b});
            end
            foreach (path[k])
                queue_expected(make_rec(sc, 1'b1, path[k][15:8], path[k][7:0],
                                        ERR_NONE, k == path.size() - 1));
        end
        model_first_len = 0;
        model_second_len = 0;
        model_overflow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            model_gap <= GAP_SYMBOL_RESET;
            model_first_len = 0;
            model_second_len = 0;
            model_overflow = 1'b0;
        end else begin
            if (i_cfg_we) model_gap <= i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                case (i_in_action)
                    ACT_LOAD_FIRST: begin
                        if (model_first_len < SEQ_MAX) model_first[model_first_len++] = i_in_symbol;
                        else model_overflow = 1'b1;
                    end
                    ACT_LOAD_SECOND: begin
                        if (model_second_len < SEQ_MAX)
                            model_second[model_second_len++] = i_in_symbol;
                        else model_overflow = 1'b1;
                    end
                    ACT_RUN: predict_alignment();
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                o_result_count++;
                if (expected_columns.size() == 0) begin
                    report_mismatch("unexpected item", i_res, '0);
                end else begin
                    t_column_rec want;
                    want = expected_columns.pop_front();
                    if (i_res.score !== want.score) report_mismatch("score", i_res, want);
                    if (i_res.has_column !== want.has_column)
                        report_mismatch("has_column", i_res, want);
                    if (i_res.first_column !== want.first_column)
                        report_mismatch("first_column", i_res, want);
                    if (i_res.second_column !== want.second_column)
                        report_mismatch("second_column", i_res, want);
                    if (i_res.error !== want.error) report_mismatch("error", i_res, want);
                    if (i_res.last !== want.last) report_mismatch("last", i_res, want);
                end
            end
        end
    end

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

endmodule

>>> tb/tb_global_sequence_alignment_unit.sv
`timescale 1ns / 100ps
// Top of the alignment testbench: clock, reset, stimulus, stalls and verdict.
module tb_global_sequence_alignment_unit;
    import gsa_pkg::*;
    import gsa_tb_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam int SEQ_LONG = 32;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_data = '0;
    int   fail_count, pending, result_count;
    int   send_idle_pct = 0, recv_idle_pct = 0;
    bit   hold_receiver = 1'b0;
    int   items_sent = 0, runs_sent = 0;
    logic [7:0] gap_now = GAP_SYMBOL_RESET;
    t_column_rec res_rec;

    gsa_in_if  in_ch();
    gsa_out_if res_ch();

    global_sequence_alignment_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_res(res_ch.source)
    );

    assign res_rec = '{score: res_ch.score, has_column: res_ch.has_column,
                       first_column: res_ch.first_column,
                       second_column: res_ch.second_column,
                       error: res_ch.error, last: res_ch.last};

    gsa_alignment_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_action(in_ch.action),
        .i_in_symbol(in_ch.symbol), .i_res_valid(res_ch.valid), .i_res_ready(res_ch.ready),
        .i_res(res_rec), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LOAD_FIRST;
        in_ch.symbol = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_receiver) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles with no accepted item on either channel.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d items still expected", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Valid stays high between back-to-back items; it drops when the sender idles.
    task automatic send_item(input logic [1:0] act, input logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.symbol <= sym;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (act == ACT_RUN) runs_sent++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_gap_symbol(input logic [7:0] val);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gap_now = val;
    endtask

    function automatic logic [7:0] pick_symbol(input int alpha);
        logic [7:0] s;
        s = 8'($urandom_range(alpha - 1)) + 8'h41;
        if ($urandom_range(19) == 0) s = 8'($urandom);
        if (s == gap_now && $urandom_range(9) != 0) s = s ^ 8'h80;
        return s;
    endfunction

    task automatic send_pair(input int n, input int m, input int alpha);
        int a, b;
        a = 0; b = 0;
        while (a < n || b < m) begin
            if (b >= m || (a < n && $urandom_range(1))) begin
                send_item(ACT_LOAD_FIRST, pick_symbol(alpha)); a++;
            end else begin
                send_item(ACT_LOAD_SECOND, pick_symbol(alpha)); b++;
            end
        end
        send_item(ACT_RUN, 8'($urandom));
    endtask

    task automatic random_phase(input int count);
        int start, r;
        start = items_sent;
        while (items_sent - start < count) begin
            r = $urandom_range(19);
            if (r == 0) send_item(ACT_IGNORED, 8'($urandom));
            else if (r == 1) send_pair(SEQ_LONG + $urandom_range(2), $urandom_range(4), 4);
            else if (r < 4) send_pair($urandom_range(24, 32), $urandom_range(24, 32), 4);
            else send_pair($urandom_range(8), $urandom_range(8), $urandom_range(1, 4));
        end
    endtask

    initial begin
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: empty run, single symbols, extremes, gap error, overflow, action 3.
        send_item(ACT_RUN, 8'h00);
        send_item(ACT_LOAD_FIRST, 8'h00);
        send_item(ACT_LOAD_SECOND, 8'hFF);
        send_item(ACT_RUN, 8'hFF);
        send_item(ACT_LOAD_FIRST, 8'hAA);
        send_item(ACT_RUN, 8'h00);
        send_item(ACT_LOAD_SECOND, 8'h55);
        send_item(ACT_RUN, 8'h00);
        send_item(ACT_LOAD_FIRST, 8'h2D);
        send_item(ACT_LOAD_SECOND, 8'h41);
        send_item(ACT_RUN, 8'h00);
        send_item(ACT_IGNORED, 8'h12);
        send_item(ACT_LOAD_FIRST, 8'h41);
        send_item(ACT_LOAD_SECOND, 8'h41);
        send_item(ACT_RUN, 8'h00);
        send_pair(33, 0, 2);
        send_pair(0, 33, 2);
        send_pair(32, 32, 1);
        set_gap_symbol(8'h00);
        send_pair(3, 2, 2);
        send_item(ACT_LOAD_FIRST, 8'h00);
        send_item(ACT_RUN, 8'h00);
        set_gap_symbol(8'hFF);
        send_pair(4, 5, 3);
        send_pair(32, 0, 2);
        send_pair(0, 32, 2);
        set_gap_symbol(8'h41);
        send_pair(6, 6, 2);

        send_idle_pct = 37; recv_idle_pct = 66;
        random_phase(30);
        set_gap_symbol(8'($urandom));
        send_idle_pct = 66; recv_idle_pct = 37;
        random_phase(30);
        set_gap_symbol(GAP_SYMBOL_RESET);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_phase(20);

        // Long receiver stall while loads and runs keep coming.
        hold_receiver = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            begin
                send_pair(20, 20, 3);
                send_pair(5, 5, 3);
            end
        join
        // Sender waits for every expected item before the last runs.
        drain_results();
        for (k = 0; k < 3; k++) send_pair($urandom_range(1, 10), $urandom_range(1, 10), 2);

        drain_results();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d input items including %0d runs; checked %0d result items.",
                 items_sent, runs_sent, result_count);
        $display("Covered empty, one-sided, full-length, overflow and gap-symbol runs.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/gsa_pkg.sv
rtl/core/gsa_if.sv
rtl/core/gsa_out_stage.sv
rtl/core/global_sequence_alignment_unit.sv
tb/gsa_tb_pkg.sv
tb/gsa_alignment_checker.sv
tb/tb_global_sequence_alignment_unit.sv
